FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define UMPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("umpq assertion failed");

// Clocked property that is also checked during reset.
`define UMPQ_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("umpq reset assertion failed");

`endif

FILE: hdl/umpq_pkg.sv
// Package: widths, command and status codes of the min-priority queue.
package umpq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;
  localparam int CMD_W     = 2;
  localparam int STS_W     = 2;
  localparam int CNT_OUT_W = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

endpackage

FILE: hdl/umpq_in_if.sv
// Request channel interface: command and push value.
interface umpq_in_if import umpq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [VAL_W-1:0]  push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

FILE: hdl/umpq_out_if.sv
// Result channel interface: minimum, status and count.
interface umpq_out_if import umpq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  min_value;
  logic [STS_W-1:0]         status;
  logic [CNT_OUT_W-1:0]     entry_count;
  logic                     is_empty;

  modport source (output valid, output min_value, output status, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input min_value, input status, input entry_count,
                  input is_empty, output ready);
endinterface

FILE: hdl/umpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module umpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/unsorted_min_priority_queue_top.sv
// Top level of the unsorted-array min-priority queue.
// Usage:
//   in_req carries one request (cmd, push_value) per valid/ready handshake;
//   out_res returns exactly one result per request, in order.
//   Push appends to the store; pop and peek scan all stored entries for the
//   smallest signed value (lowest index on ties); pop then moves the last
//   entry into the freed slot.
// Sequence (receiver ready):
//   One request at a time. Push, unused codes and pop or peek on an empty
//   queue go from ST_IDLE to ST_FIN, whose result is registered in the
//   output register as the FSM returns to ST_IDLE to take the next request.
//   Pop and peek with stored entries first pass through ST_SCAN, which reads
//   every stored entry through the single read port of the value RAM (one
//   entry read per cycle, registered read data) before ST_FIN.
//   The pop write-back of the last entry shares the cycle of the final read.
// Reset: rst_n (synchronous, active low) empties the queue; RAM contents are
//   not cleared, only entries below the count are ever read.
// Stall: a result waits in the output register while out_res.ready is low;
//   the next request is still accepted and finishes when the register frees.
module unsorted_min_priority_queue_top import umpq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  umpq_in_if.sink    in_req,
  umpq_out_if.source out_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                  st_r;
  logic [CMD_W-1:0]        cmd_r;
  logic [STS_W-1:0]        status_r;
  logic [CW-1:0]           cnt_r;
  logic [CW-1:0]           rd_ptr_r;
  logic                    dv_r;
  logic [AW-1:0]           didx_r;
  logic signed [VAL_W-1:0] best_val_r;
  logic [AW-1:0]           best_idx_r;

  logic                    ov_r;
  logic signed [VAL_W-1:0] omin_r;
  logic [STS_W-1:0]        ostat_r;
  logic [CNT_OUT_W-1:0]    ocnt_r;
  logic                    oempty_r;

  logic                    accept, full, empty, issue, last, first, take, out_free;
  logic [CW-1:0]           cnt_m1;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;
  logic signed [VAL_W-1:0] rd_data, cur_val;
  logic [AW-1:0]           cur_idx;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [VAL_W-1:0]        ram_wdata;

  assign in_req.ready = (st_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign full         = (cnt_r == CW'(DEPTH));
  assign empty        = (cnt_r == '0);
  assign cnt_m1       = cnt_r - 1'b1;
  assign cnt_ext      = {{CNT_OUT_W{1'b0}}, cnt_r};
  assign issue        = (st_r == ST_SCAN) && (rd_ptr_r != cnt_r);
  assign first        = dv_r && (didx_r == '0);
  assign last         = dv_r && (didx_r == cnt_m1[AW-1:0]);
  assign take         = first || (rd_data < best_val_r);
  assign cur_val      = take ? rd_data : best_val_r;
  assign cur_idx      = take ? didx_r : best_idx_r;
  assign out_free     = !ov_r || out_res.ready;

  always_comb begin
    if (st_r == ST_IDLE) begin
      ram_we    = accept && (in_req.cmd == CMD_PUSH) && !full;
      ram_waddr = cnt_r[AW-1:0];
      ram_wdata = in_req.push_value;
    end else begin
      ram_we    = last && (cmd_r == CMD_POP);
      ram_waddr = cur_idx;
      ram_wdata = rd_data;
    end
  end

  umpq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_umpq_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr_r[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      cnt_r    <= '0;
      rd_ptr_r <= '0;
      dv_r     <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      dv_r <= issue;
      if (issue) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (ov_r && out_res.ready) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (accept) begin
            rd_ptr_r <= '0;
            st_r     <= ST_FIN;
            case (in_req.cmd)
              CMD_PUSH: begin
                if (!full) begin
                  cnt_r <= cnt_r + 1'b1;
                end
              end
              CMD_POP, CMD_PEEK: begin
                if (!empty) begin
                  st_r <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (last) begin
            if (cmd_r == CMD_POP) begin
              cnt_r <= cnt_m1;
            end
            st_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            ov_r <= 1'b1;
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= rd_ptr_r[AW-1:0];
    if (dv_r) begin
      best_val_r <= cur_val;
      best_idx_r <= cur_idx;
    end
    if (accept) begin
      cmd_r <= in_req.cmd;
      if ((in_req.cmd == CMD_PUSH) && full) begin
        status_r <= STS_FULL;
      end else if (((in_req.cmd == CMD_POP) || (in_req.cmd == CMD_PEEK)) && empty) begin
        status_r <= STS_EMPTY;
      end else begin
        status_r <= STS_OK;
      end
    end
    if ((st_r == ST_FIN) && out_free) begin
      omin_r   <= ((status_r == STS_OK) && ((cmd_r == CMD_POP) || (cmd_r == CMD_PEEK)))
                  ? best_val_r : '0;
      ostat_r  <= status_r;
      ocnt_r   <= cnt_ext[CNT_OUT_W-1:0];
      oempty_r <= empty;
    end
  end

  assign out_res.valid       = ov_r;
  assign out_res.min_value   = omin_r;
  assign out_res.status      = ostat_r;
  assign out_res.entry_count = ocnt_r;
  assign out_res.is_empty    = oempty_r;

endmodule

FILE: hdl/umpq_checker.sv
// Port-level checker for the min-priority queue, bound to the top level.
`include "assert_macros.svh"

module umpq_checker import umpq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] out_min_value,
  input logic [STS_W-1:0]        out_status,
  input logic [CNT_OUT_W-1:0]    out_entry_count,
  input logic                    out_is_empty
);

  localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(DEPTH);

  logic empty_res_ok;
  logic full_res_ok;

  assign empty_res_ok = out_is_empty && (out_min_value == '0);
  assign full_res_ok  = (out_entry_count == FULL_CNT) && !out_is_empty;

  `UMPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `UMPQ_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready)
  `UMPQ_ASSERT(a_empty_res, out_valid && (out_status == STS_EMPTY) |-> empty_res_ok)
  `UMPQ_ASSERT(a_full_res, out_valid && (out_status == STS_FULL) |-> full_res_ok)
  `UMPQ_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid)

endmodule

bind unsorted_min_priority_queue_top umpq_checker #(.DEPTH(DEPTH)) u_umpq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_min_value   (out_res.min_value),
  .out_status      (out_res.status),
  .out_entry_count (out_res.entry_count),
  .out_is_empty    (out_res.is_empty)
);

FILE: tb/sv/testbench.sv
// Testbench for the unsorted min-priority queue: requests checked against a shadow queue.
`timescale 1ns / 1ps

module testbench import umpq_pkg::*; ();

  localparam int QDEPTH         = DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct {
    logic signed [VAL_W-1:0] min_value;
    logic [STS_W-1:0]        status;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic                    is_empty;
  } queue_result_t;

  logic clk;
  logic rst_n;

  umpq_in_if  in_req ();
  umpq_out_if out_res ();

  unsorted_min_priority_queue_top #(.DEPTH(QDEPTH)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req.sink),
    .out_res (out_res.source)
  );

  logic signed [VAL_W-1:0] shadow_store [QDEPTH];
  int                      shadow_count;
  queue_result_t           expected_results [$];

  int in_idle_pct;
  int out_stall_pct;
  int hold_request;
  int mismatch_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow of the queue: updated once per accepted request.
  function automatic queue_result_t predict_queue_result(input logic [CMD_W-1:0] op,
                                                         input logic signed [VAL_W-1:0] value);
    queue_result_t res;
    int best;
    res.min_value = '0;
    res.status    = STS_OK;
    case (op)
      CMD_PUSH: begin
        if (shadow_count >= QDEPTH) begin
          res.status = STS_FULL;
        end else begin
          shadow_store[shadow_count] = value;
          shadow_count++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (shadow_count == 0) begin
          res.status = STS_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < shadow_count; i++) begin
            if (shadow_store[i] < shadow_store[best]) best = i;
          end
          res.min_value = shadow_store[best];
          if (op == CMD_POP) begin
            shadow_store[best] = shadow_store[shadow_count-1];
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_OUT_W'(shadow_count);
    res.is_empty    = (shadow_count == 0);
    return res;
  endfunction

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3, 4, 5: return VAL_W'($urandom_range(15)) - VAL_W'(8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] op, input logic signed [VAL_W-1:0] value);
    if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_req.valid      <= 1'b1;
    in_req.cmd        <= op;
    in_req.push_value <= value;
    do @(posedge clk); while (!in_req.ready);
    expected_results.insert(expected_results.size(), predict_queue_result(op, value));
  endtask

  task automatic test_empty_ops();
    send_request(CMD_POP, VAL_MAX);
    send_request(CMD_PEEK, VAL_MIN);
    send_request(CMD_UNUSED, '1);
  endtask

  // Extremes, duplicates of the minimum, and draining past empty.
  task automatic test_extremes();
    send_request(CMD_PUSH, VAL_MAX);
    send_request(CMD_PUSH, VAL_MIN);
    send_request(CMD_PUSH, '0);
    send_request(CMD_PUSH, '1);
    send_request(CMD_PUSH, VAL_MIN);
    send_request(CMD_PUSH, VAL_MAX);
    send_request(CMD_PEEK, '0);
    send_request(CMD_UNUSED, VAL_MIN);
    send_request(CMD_POP, '0);
    send_request(CMD_POP, '0);
    send_request(CMD_PEEK, '0);
    repeat (4) send_request(CMD_POP, '0);
    send_request(CMD_POP, '0);
    send_request(CMD_PEEK, '0);
  endtask

  task automatic test_random_mix(input int count);
    int push_pct;
    int pick;
    repeat (count) begin
      push_pct = (shadow_count < 8) ? 65 : (shadow_count > 56) ? 30 : 50;
      pick     = $urandom_range(99);
      if (pick < push_pct) begin
        send_request(CMD_PUSH, random_value());
      end else if (pick < 96) begin
        send_request($urandom_range(1) ? CMD_POP : CMD_PEEK, random_value());
      end else begin
        send_request(CMD_UNUSED, random_value());
      end
    end
  endtask

  task automatic test_fill_drain();
    while (shadow_count < QDEPTH) send_request(CMD_PUSH, random_value());
    repeat (3) send_request(CMD_PUSH, random_value());
    send_request(CMD_PEEK, random_value());
    while (shadow_count > 0) begin
      send_request(($urandom_range(3) == 0) ? CMD_PEEK : CMD_POP, random_value());
    end
    send_request(CMD_POP, random_value());
  endtask

  // Receiver holds off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_request = LONG_HOLD;
    repeat (30) begin
      send_request($urandom_range(2) == 0 ? CMD_PEEK : CMD_PUSH, random_value());
    end
  endtask

  initial begin
    out_res.ready = 1'b0;
    forever begin : receiver
      int hold_left;
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_res.ready <= 1'b0;
        hold_left--;
      end else begin
        out_res.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    queue_result_t exp_res;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: min_value %0d status %0d count %0d empty %0b",
                   out_res.min_value, out_res.status, out_res.entry_count, out_res.is_empty);
        end
      end else begin
        exp_res = expected_results.pop_front();
        if (out_res.min_value !== exp_res.min_value || out_res.status !== exp_res.status ||
            out_res.entry_count !== exp_res.entry_count ||
            out_res.is_empty !== exp_res.is_empty) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"mismatch (exp/act): min_value %0d/%0d status %0d/%0d",
                      " count %0d/%0d empty %0b/%0b"},
                     exp_res.min_value, out_res.min_value, exp_res.status, out_res.status,
                     exp_res.entry_count, out_res.entry_count, exp_res.is_empty,
                     out_res.is_empty);
          end
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_req.valid      = 1'b0;
    in_req.cmd        = CMD_PUSH;
    in_req.push_value = '0;
    in_idle_pct       = 0;
    out_stall_pct     = 0;
    hold_request      = 0;
    mismatch_count    = 0;
    shadow_count      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_ops();
    test_extremes();
    test_random_mix(300);
    test_fill_drain();

    in_idle_pct = 62;
    test_random_mix(300);

    in_idle_pct   = 0;
    out_stall_pct = 62;
    test_random_mix(300);
    test_fill_drain();

    in_idle_pct   = 7;
    out_stall_pct = 7;
    test_random_mix(300);

    in_idle_pct   = 0;
    out_stall_pct = 0;
    test_backpressure();

    in_req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (QDEPTH + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
